### rtl/assert_macros.svh
// Assertion macros shared by the session table RTL.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define STI_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("session table assertion failed");

// Next-cycle implication, checked outside reset.
`define STI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("session table assertion failed");

`endif

### rtl/sti_pkg.sv
// Shared types and codes for the session table with idle timeout.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package sti_pkg;

    localparam int KEY_W = 64;
    localparam int TIME_W = 32;
    localparam int CMD_W = 2;
    localparam int STATUS_W = 2;
    localparam int COUNT_OUT_W = 7;

    localparam logic [TIME_W-1:0] IDLE_LIMIT_RST = 32'd1800;

    typedef enum logic [CMD_W-1:0] {
        CMD_CREATE   = 2'd0,
        CMD_VALIDATE = 2'd1,
        CMD_DESTROY  = 2'd2,
        CMD_CLEANUP  = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EXPIRED   = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] last_seen;
    } entry_t;

    // Result of comparing one stored entry against the current command.
    typedef struct packed {
        logic match;
        logic expired;
    } cmp_t;

endpackage

### rtl/sti_mem.sv
// Entry storage for the session table: one write port, one registered read port.
// Depends on sti_pkg for the entry type.
`timescale 1ns / 1ps

module sti_mem #(
    parameter int DEPTH = 64
) (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [$clog2(DEPTH)-1:0]      wr_addr,
    input  sti_pkg::entry_t               wr_data,
    input  logic [$clog2(DEPTH)-1:0]      rd_addr,
    output sti_pkg::entry_t               rd_data
);

    sti_pkg::entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

### rtl/sti_cmp.sv
// Shared compare unit: key match and idle-age check for one entry.
// Depends on sti_pkg for the entry and result types.
`timescale 1ns / 1ps

module sti_cmp (
    input  sti_pkg::entry_t                 entry,
    input  logic [sti_pkg::KEY_W-1:0]       key,
    input  logic [sti_pkg::TIME_W-1:0]      now,
    input  logic [sti_pkg::TIME_W-1:0]      idle_limit,
    output sti_pkg::cmp_t                   result
);

    logic [sti_pkg::TIME_W-1:0] idle;

    // The subtraction wraps modulo 2^32, matching the tick counter.
    assign idle = now - entry.last_seen;

    always_comb
    begin
        result.match   = (entry.key == key);
        result.expired = (idle > idle_limit);
    end

endmodule

### rtl/session_table_idle_timeout.sv
// Top level of the session table with idle timeout: sequencer and registers.
// Depends on sti_pkg, sti_mem, sti_cmp and assert_macros.svh.
//
//  Channel   Signals                                   Direction
//  in        in_valid, in_ready, command,              into block
//            session_key, now
//  out       out_valid, out_ready, status,             out of block
//            live_count, removed_count
//  cfg       cfg_we, cfg_wdata (idle limit)            into block
//
// Create appends its entry, if there is room, when the item is accepted. Validate,
// destroy and cleanup scan the table with one memory read port and one compare unit,
// taking every entry held when the item is accepted through S_READ and then S_EVAL.
// The block takes a new item only when the sequencer is idle; a finished
// result waits in the output register while the next item is accepted.
// Reset is asynchronous and empties the table; no clearing pass is needed.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module session_table_idle_timeout #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [sti_pkg::TIME_W-1:0]          cfg_wdata,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [sti_pkg::CMD_W-1:0]           command,
    input  logic [sti_pkg::KEY_W-1:0]           session_key,
    input  logic [sti_pkg::TIME_W-1:0]          now,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [sti_pkg::STATUS_W-1:0]        status,
    output logic [sti_pkg::COUNT_OUT_W-1:0]     live_count,
    output logic [sti_pkg::COUNT_OUT_W-1:0]     removed_count
);

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_EVAL = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t                         state_reg, state_next;
    sti_pkg::cmd_t                  cmd_reg, cmd_next;
    logic [sti_pkg::KEY_W-1:0]      key_reg, key_next;
    logic [sti_pkg::TIME_W-1:0]     now_reg, now_next;
    logic [sti_pkg::TIME_W-1:0]     limit_reg, limit_next;
    logic [AW-1:0]                  rd_reg, rd_next;
    logic [CNT_W-1:0]               wr_reg, wr_next;
    logic [CNT_W-1:0]               count_reg, count_next;
    logic [CNT_W-1:0]               removed_reg, removed_next;
    logic                           found_reg, found_next;
    logic                           expired_reg, expired_next;
    logic                           out_valid_reg, out_valid_next;
    sti_pkg::status_t               status_reg, status_next;
    logic [sti_pkg::COUNT_OUT_W-1:0] live_reg, live_next;
    logic [sti_pkg::COUNT_OUT_W-1:0] removed_out_reg, removed_out_next;

    logic                           mem_wr_en;
    logic [AW-1:0]                  mem_wr_addr;
    sti_pkg::entry_t                mem_wr_data;
    sti_pkg::entry_t                mem_rd_data;
    sti_pkg::cmp_t                  cmp;

    logic                           is_first;
    logic                           drop;
    logic                           refresh;
    logic                           last_entry;
    logic                           in_beat;

    sti_mem #(
        .DEPTH (MAX_ENTRIES)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (rd_reg),
        .rd_data (mem_rd_data)
    );

    sti_cmp u_cmp (
        .entry      (mem_rd_data),
        .key        (key_reg),
        .now        (now_reg),
        .idle_limit (limit_reg),
        .result     (cmp)
    );

    assign in_ready      = (state_reg == S_IDLE);
    assign in_beat       = in_valid && in_ready;
    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign live_count    = live_reg;
    assign removed_count = removed_out_reg;

    // Decisions for the entry currently on the read port.
    assign is_first   = cmp.match && !found_reg;
    assign drop       = ((cmd_reg == sti_pkg::CMD_CLEANUP) && cmp.expired)
                     || ((cmd_reg == sti_pkg::CMD_DESTROY) && is_first);
    assign refresh    = (cmd_reg == sti_pkg::CMD_VALIDATE) && is_first && !cmp.expired;
    assign last_entry = ((CNT_W'(rd_reg) + CNT_W'(1)) == count_reg);

    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        key_next         = key_reg;
        now_next         = now_reg;
        limit_next       = cfg_we ? cfg_wdata : limit_reg;
        rd_next          = rd_reg;
        wr_next          = wr_reg;
        count_next       = count_reg;
        removed_next     = removed_reg;
        found_next       = found_reg;
        expired_next     = expired_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        status_next      = status_reg;
        live_next        = live_reg;
        removed_out_next = removed_out_reg;
        mem_wr_en        = 1'b0;
        mem_wr_addr      = count_reg[AW-1:0];
        mem_wr_data.key       = key_reg;
        mem_wr_data.last_seen = now_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_beat)
                begin
                    cmd_next     = sti_pkg::cmd_t'(command);
                    key_next     = session_key;
                    now_next     = now;
                    rd_next      = '0;
                    wr_next      = '0;
                    removed_next = '0;
                    found_next   = 1'b0;
                    expired_next = 1'b0;
                    if (sti_pkg::cmd_t'(command) == sti_pkg::CMD_CREATE)
                    begin
                        // For create, found marks a successful append.
                        if (count_reg < MAX_CNT)
                        begin
                            mem_wr_en             = 1'b1;
                            mem_wr_data.key       = session_key;
                            mem_wr_data.last_seen = now;
                            count_next            = count_reg + CNT_W'(1);
                            found_next            = 1'b1;
                        end
                        state_next = S_DONE;
                    end
                    else if (count_reg == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end

            S_READ:
            begin
                state_next = S_EVAL;
            end

            S_EVAL:
            begin
                // Kept entries slide down to the write pointer; a refreshed
                // entry is written back in place with the new timestamp.
                if (!drop && ((wr_reg != CNT_W'(rd_reg)) || refresh))
                begin
                    mem_wr_en             = 1'b1;
                    mem_wr_addr           = wr_reg[AW-1:0];
                    mem_wr_data.key       = mem_rd_data.key;
                    mem_wr_data.last_seen = refresh ? now_reg : mem_rd_data.last_seen;
                end
                if (is_first)
                begin
                    found_next   = 1'b1;
                    expired_next = cmp.expired;
                end
                removed_next = removed_reg + CNT_W'(drop);
                wr_next      = wr_reg + CNT_W'(!drop);
                if (last_entry)
                begin
                    count_next = wr_reg + CNT_W'(!drop);
                    state_next = S_DONE;
                end
                else
                begin
                    rd_next    = rd_reg + AW'(1);
                    state_next = S_READ;
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next   = 1'b1;
                    live_next        = sti_pkg::COUNT_OUT_W'(count_reg);
                    removed_out_next = sti_pkg::COUNT_OUT_W'(removed_reg);
                    case (cmd_reg)
                        sti_pkg::CMD_CREATE:
                            status_next = found_reg ? sti_pkg::ST_OK : sti_pkg::ST_FULL;
                        sti_pkg::CMD_VALIDATE:
                            status_next = !found_reg  ? sti_pkg::ST_NOT_FOUND :
                                          expired_reg ? sti_pkg::ST_EXPIRED : sti_pkg::ST_OK;
                        sti_pkg::CMD_DESTROY:
                            status_next = found_reg ? sti_pkg::ST_OK : sti_pkg::ST_NOT_FOUND;
                        default:
                            status_next = sti_pkg::ST_OK;
                    endcase
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            limit_reg     <= sti_pkg::IDLE_LIMIT_RST;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            expired_reg   <= 1'b0;
            rd_reg        <= '0;
            wr_reg        <= '0;
            removed_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            limit_reg     <= limit_next;
            out_valid_reg <= out_valid_next;
            found_reg     <= found_next;
            expired_reg   <= expired_next;
            rd_reg        <= rd_next;
            wr_reg        <= wr_next;
            removed_reg   <= removed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        key_reg         <= key_next;
        now_reg         <= now_next;
        status_reg      <= status_next;
        live_reg        <= live_next;
        removed_out_reg <= removed_out_next;
    end

    `STI_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= MAX_CNT)
    `STI_ASSERT_SAME(a_compact_order, state_reg == S_EVAL, wr_reg <= CNT_W'(rd_reg))
    `STI_ASSERT_NEXT(a_eval_last_done, (state_reg == S_EVAL) && last_entry, state_reg == S_DONE)
    `STI_ASSERT_NEXT(a_create_grows,
        in_beat && (command == sti_pkg::CMD_CREATE) && (count_reg < MAX_CNT),
        count_reg == $past(count_reg) + CNT_W'(1))

endmodule

### tb/tb_session_table_idle_timeout.sv
// Self-checking testbench for session_table_idle_timeout: directed and random commands
// checked beat by beat against an in-bench model of the session table.
// Depends on sti_pkg and the session_table_idle_timeout RTL.
`timescale 1ns / 1ps

module tb_session_table_idle_timeout;

    localparam int MAX_ENTRIES = 64;
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 600;
    localparam int KEY_POOL = 12;

    typedef struct packed {
        sti_pkg::cmd_t              op;
        logic [sti_pkg::KEY_W-1:0]  key;
        logic [sti_pkg::TIME_W-1:0] stamp;
    } session_cmd_t;

    typedef struct packed {
        sti_pkg::status_t                status;
        logic [sti_pkg::COUNT_OUT_W-1:0] live;
        logic [sti_pkg::COUNT_OUT_W-1:0] removed;
    } session_result_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_we = 1'b0;
    logic [sti_pkg::TIME_W-1:0]      cfg_wdata = '0;
    logic                            in_valid = 1'b0;
    logic                            in_ready;
    logic [sti_pkg::CMD_W-1:0]       command = '0;
    logic [sti_pkg::KEY_W-1:0]       session_key = '0;
    logic [sti_pkg::TIME_W-1:0]      now = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    logic [sti_pkg::STATUS_W-1:0]    status;
    logic [sti_pkg::COUNT_OUT_W-1:0] live_count;
    logic [sti_pkg::COUNT_OUT_W-1:0] removed_count;

    // Model of the table contents and the idle limit as the block should hold them.
    logic [sti_pkg::KEY_W-1:0]  tbl_key [MAX_ENTRIES];
    logic [sti_pkg::TIME_W-1:0] tbl_seen [MAX_ENTRIES];
    int                         tbl_count = 0;
    logic [sti_pkg::TIME_W-1:0] active_limit = sti_pkg::IDLE_LIMIT_RST;

    session_cmd_t    cmd_backlog [$];
    session_result_t pending_results [$];
    session_cmd_t    on_wire;
    session_result_t want;

    logic [sti_pkg::KEY_W-1:0]  key_pool [KEY_POOL];
    logic [sti_pkg::TIME_W-1:0] tick = '0;
    logic              calm = 1'b0;
    logic              hold_go = 1'b0;
    logic              hold_done = 1'b0;
    int                hold_left = 0;
    int                fault_count = 0;
    int                quiet_cycles = 0;

    session_table_idle_timeout #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .command(command),
        .session_key(session_key),
        .now(now),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .status(status),
        .live_count(live_count),
        .removed_count(removed_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int find_key(logic [sti_pkg::KEY_W-1:0] key);
        for (int i = 0; i < tbl_count; i++)
        begin
            if (tbl_key[i] == key)
                return i;
        end
        return -1;
    endfunction

    // Idle time wraps modulo 2^32, so the subtraction stays at 32 bits.
    function automatic logic aged_out(int idx, logic [sti_pkg::TIME_W-1:0] t);
        logic [sti_pkg::TIME_W-1:0] idle;
        idle = t - tbl_seen[idx];
        return idle > active_limit;
    endfunction

    function automatic session_result_t apply_command(session_cmd_t c);
        session_result_t r;
        int hit;
        int wr;
        r.status = sti_pkg::ST_OK;
        r.removed = '0;
        case (c.op)
            sti_pkg::CMD_CREATE:
            begin
                if (tbl_count >= MAX_ENTRIES)
                    r.status = sti_pkg::ST_FULL;
                else
                begin
                    tbl_key[tbl_count] = c.key;
                    tbl_seen[tbl_count] = c.stamp;
                    tbl_count++;
                end
            end
            sti_pkg::CMD_VALIDATE:
            begin
                hit = find_key(c.key);
                if (hit < 0)
                    r.status = sti_pkg::ST_NOT_FOUND;
                else if (aged_out(hit, c.stamp))
                    r.status = sti_pkg::ST_EXPIRED;
                else
                    tbl_seen[hit] = c.stamp;
            end
            sti_pkg::CMD_DESTROY:
            begin
                hit = find_key(c.key);
                if (hit < 0)
                    r.status = sti_pkg::ST_NOT_FOUND;
                else
                begin
                    for (int j = hit; j + 1 < tbl_count; j++)
                    begin
                        tbl_key[j] = tbl_key[j + 1];
                        tbl_seen[j] = tbl_seen[j + 1];
                    end
                    tbl_count--;
                    r.removed = 7'd1;
                end
            end
            default:
            begin
                wr = 0;
                for (int rd = 0; rd < tbl_count; rd++)
                begin
                    if (aged_out(rd, c.stamp))
                        r.removed++;
                    else
                    begin
                        tbl_key[wr] = tbl_key[rd];
                        tbl_seen[wr] = tbl_seen[rd];
                        wr++;
                    end
                end
                tbl_count = wr;
            end
        endcase
        r.live = tbl_count[sti_pkg::COUNT_OUT_W-1:0];
        return r;
    endfunction

    // Driver: offers the next queued command, predicting its result when the beat is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                pending_results.push_back(apply_command(on_wire));
            if (!in_valid || in_ready)
            begin
                if (cmd_backlog.size() != 0 && (calm || $urandom_range(99) >= 25))
                begin
                    on_wire = cmd_backlog.pop_front();
                    command <= on_wire.op;
                    session_key <= on_wire.key;
                    now <= on_wire.stamp;
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result beat against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    if (fault_count < 10)
                        $display("unexpected result beat: status=%0d live=%0d removed=%0d",
                                 status, live_count, removed_count);
                    fault_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (status !== want.status || live_count !== want.live
                        || removed_count !== want.removed)
                    begin
                        if (fault_count < 10)
                            $display("mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                                     want.status, want.live, want.removed,
                                     status, live_count, removed_count);
                        fault_count++;
                    end
                end
            end
            if (hold_go && !hold_done)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= calm || ($urandom_range(99) >= 25);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    task automatic add_cmd(sti_pkg::cmd_t op, logic [sti_pkg::KEY_W-1:0] key,
                           logic [sti_pkg::TIME_W-1:0] t);
        session_cmd_t c;
        c.op = op;
        c.key = key;
        c.stamp = t;
        cmd_backlog.push_back(c);
    endtask

    task automatic drain();
        while (cmd_backlog.size() != 0 || in_valid || pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_limit(logic [sti_pkg::TIME_W-1:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        active_limit = v;
    endtask

    // Random traffic over a small key pool so lookups hit, with time mostly creeping forward.
    task automatic queue_traffic(int n, int create_pct, int step_max);
        int pick;
        int rest;
        sti_pkg::cmd_t op;
        logic [sti_pkg::KEY_W-1:0] key;
        logic [sti_pkg::TIME_W-1:0] t;
        for (int i = 0; i < KEY_POOL; i++)
            key_pool[i] = {$urandom, $urandom};
        for (int n_done = 0; n_done < n; n_done++)
        begin
            pick = $urandom_range(99);
            rest = $urandom_range(99);
            if (pick < create_pct)
                op = sti_pkg::CMD_CREATE;
            else if (rest < 50)
                op = sti_pkg::CMD_VALIDATE;
            else if (rest < 80)
                op = sti_pkg::CMD_DESTROY;
            else
                op = sti_pkg::CMD_CLEANUP;
            if ($urandom_range(99) < 85)
                key = key_pool[$urandom_range(KEY_POOL - 1)];
            else
                key = {$urandom, $urandom};
            pick = $urandom_range(99);
            if (pick < 4)
                t = $urandom;
            else
            begin
                if (pick < 7)
                    tick = tick + active_limit + $urandom_range(1, 100);
                else
                    tick = tick + $urandom_range(0, step_max);
                t = tick;
            end
            add_cmd(op, key, t);
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes, wraparound idle time, expiry at and past the limit,
        // duplicates, missing keys and a cleanup that removes nothing.
        add_cmd(sti_pkg::CMD_CREATE, 64'h0, 32'h0);
        add_cmd(sti_pkg::CMD_CREATE, {sti_pkg::KEY_W{1'b1}}, 32'hFFFF_FFFF);
        add_cmd(sti_pkg::CMD_CREATE, 64'h5555_5555_AAAA_AAAA, 32'd100);
        add_cmd(sti_pkg::CMD_VALIDATE, 64'h0, 32'd1800);
        add_cmd(sti_pkg::CMD_VALIDATE, {sti_pkg::KEY_W{1'b1}}, 32'd1799);
        add_cmd(sti_pkg::CMD_VALIDATE, 64'h0, 32'd3601);
        add_cmd(sti_pkg::CMD_VALIDATE, 64'h1234_0000_0000_0001, 32'd3601);
        add_cmd(sti_pkg::CMD_DESTROY, 64'h1234_0000_0000_0001, 32'd3601);
        add_cmd(sti_pkg::CMD_CREATE, 64'h0, 32'd3601);
        add_cmd(sti_pkg::CMD_DESTROY, 64'h0, 32'd3601);
        add_cmd(sti_pkg::CMD_VALIDATE, 64'h0, 32'd3602);
        add_cmd(sti_pkg::CMD_CLEANUP, 64'hDEAD_BEEF_0000_FFFF, 32'd3602);
        add_cmd(sti_pkg::CMD_CLEANUP, 64'h0, 32'd3602);
        add_cmd(sti_pkg::CMD_DESTROY, 64'h0, 32'd3602);
        add_cmd(sti_pkg::CMD_DESTROY, 64'h0, 32'd3602);
        add_cmd(sti_pkg::CMD_VALIDATE, 64'hAAAA_5555_0F0F_F0F0, 32'h8000_0000);
        add_cmd(sti_pkg::CMD_CLEANUP, {sti_pkg::KEY_W{1'b1}}, 32'hFFFF_FFFF);
        drain();

        // Limit at its top: nothing ever ages out, so creates fill the table.
        set_limit(32'hFFFF_FFFF);
        queue_traffic(200, 85, 50);
        drain();

        set_limit(32'h0);
        queue_traffic(250, 40, 2);
        drain();

        // Time near the wrap point, and a stretch with no idling on either side.
        set_limit(sti_pkg::IDLE_LIMIT_RST);
        tick = 32'hFFFF_F000;
        calm = 1'b1;
        queue_traffic(400, 45, 700);
        drain();
        calm = 1'b0;

        // The receiver holds off for a long while so the block backs up its input.
        set_limit($urandom_range(50, 500));
        queue_traffic(300, 45, 200);
        hold_go = 1'b1;
        drain();

        set_limit(32'd1);
        queue_traffic(200, 45, 2);
        drain();

        set_limit($urandom);
        queue_traffic(500, 45, 1000);
        drain();

        repeat (150) @(posedge clk);
        if (fault_count == 0 && pending_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### session_table_idle_timeout.f
+incdir+rtl
rtl/sti_pkg.sv
rtl/sti_mem.sv
rtl/sti_cmp.sv
rtl/session_table_idle_timeout.sv
tb/tb_session_table_idle_timeout.sv
